### hdl/bved_pkg.sv
package bved_pkg;

  localparam int PatBases = 256;
  localparam int PosW     = $clog2(PatBases);
  localparam int LenW     = PosW + 1;
  localparam int ScoreW   = 10;
  localparam int Bases    = 4;
  localparam int BaseW    = $clog2(Bases);

  localparam logic [ScoreW-1:0] ScoreCeil = {ScoreW{1'b1}};
  localparam logic [LenW-1:0]   ThrCap    = LenW'(PatBases);
  localparam logic [LenW-1:0]   ResetLen  = LenW'(64);

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_TEXT = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_PAT_LEN   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PatBases-1:0] vp;
    logic [PatBases-1:0] vn;
    logic [ScoreW-1:0]   score;
  } step_t;

  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] raw);
    logic [LenW-1:0] m;
    m = raw;
    if (raw == '0) begin
      m = LenW'(1);
    end else if (raw > ThrCap) begin
      m = ThrCap;
    end
    return m;
  endfunction

  function automatic logic [PatBases-1:0] len_mask(input logic [LenW-1:0] m);
    logic [PatBases-1:0] msk;
    for (int i = 0; i < PatBases; i++) begin
      msk[i] = (LenW'(i) < m);
    end
    return msk;
  endfunction

endpackage

### hdl/bved_if.sv
interface bved_item_if;
  import bved_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [BaseW-1:0] base;
  logic [PosW-1:0]  position;
  logic             last;
  modport source (output valid, func, base, position, last, input ready);
  modport sink   (input valid, func, base, position, last, output ready);
endinterface

interface bved_result_if;
  import bved_pkg::*;
  logic            valid;
  logic            ready;
  logic [LenW-1:0] distance;
  logic            rejected;
  modport source (output valid, distance, rejected, input ready);
  modport sink   (input valid, distance, rejected, output ready);
endinterface

interface bved_cfg_if;
  import bved_pkg::*;
  logic            valid;
  logic            ready;
  logic            index;
  logic [LenW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bved_step.sv
module bved_step (
  input  logic [bved_pkg::PatBases-1:0] eq,
  input  logic [bved_pkg::PatBases-1:0] vp,
  input  logic [bved_pkg::PatBases-1:0] vn,
  input  logic [bved_pkg::PatBases-1:0] mask,
  input  logic [bved_pkg::PosW-1:0]     top,
  input  logic [bved_pkg::ScoreW-1:0]   score,
  output bved_pkg::step_t               nxt
);
  import bved_pkg::*;

  logic [PatBases-1:0] x;
  logic [PatBases-1:0] sum;
  logic [PatBases-1:0] d0;
  logic [PatBases-1:0] hp;
  logic [PatBases-1:0] hn;
  logic [PatBases-1:0] hps;
  logic [PatBases-1:0] hns;

  assign x   = eq | vn;
  assign sum = (x & vp) + vp;
  assign d0  = ((sum ^ vp) | x) & mask;
  assign hp  = (vn | ~(d0 | vp)) & mask;
  assign hn  = d0 & vp & mask;
  assign hps = {hp[PatBases-2:0], 1'b1} & mask;
  assign hns = {hn[PatBases-2:0], 1'b0} & mask;

  always_comb begin
    nxt.vn    = hps & d0;
    nxt.vp    = (hns | ~(hps | d0)) & mask;
    nxt.score = score;
    if (hp[top]) begin
      if (score != ScoreCeil) nxt.score = score + ScoreW'(1);
    end else if (hn[top]) begin
      if (score != '0) nxt.score = score - ScoreW'(1);
    end
  end

endmodule

### hdl/bit_vector_edit_distance_dna_core.sv
// Bit-vector edit distance between a stored DNA pattern and a streamed text.
// Channels (valid/ready, a beat moves at an edge with both high):
//   item   : func=0 loads pattern base 'base' at 'position'; func=1 feeds a
//            text base, 'last' marks the end of the text.
//   result : one beat per text, on the last base: distance, saturated to
//            threshold+1, and rejected when saturated.
//   cfg    : index 0 threshold, index 1 pattern length; always ready. Writing
//            the pattern length restarts the vectors and the score.
// Throughput: one item per cycle while no result is stalled; the 256-bit add
// of the recurrence and the score update are combinational between the item
// register and the state and result registers.
// The last text base is registered in the item register; its result beat is then registered in the result register.
// Reset (synchronous): pattern bitmaps cleared, threshold 0, pattern length
// 64, vectors and score at their start values, no result pending.
// Stall: a result waits in the output register; one more item may enter
// behind it, and further items are held back only when that item must also
// deliver a result.
module bit_vector_edit_distance_dna_core (
  input logic           clk,
  input logic           rst,
  bved_item_if.sink     item,
  bved_result_if.source result,
  bved_cfg_if.sink      cfg
);
  import bved_pkg::*;

  logic                s1_valid;
  logic                s1_func;
  logic [BaseW-1:0]    s1_base;
  logic [PosW-1:0]     s1_pos;
  logic                s1_last;

  logic                res_valid;
  logic [LenW-1:0]     res_distance;
  logic                res_rejected;

  logic [PatBases-1:0] bitmaps [Bases];
  logic [PatBases-1:0] vp;
  logic [PatBases-1:0] vn;
  logic [PatBases-1:0] mask;
  logic [LenW-1:0]     eff;
  logic [PosW-1:0]     top;
  logic [LenW-1:0]     thr;
  logic [ScoreW-1:0]   score;

  logic                s1_text;
  logic                s1_result;
  logic                out_free;
  logic                s1_go;
  logic                len_wr;
  logic [LenW-1:0]     new_eff;
  logic [PatBases-1:0] new_mask;
  step_t               nxt;

  assign s1_text   = s1_valid && (s1_func == FUNC_TEXT);
  assign s1_result = s1_text && s1_last;
  assign out_free  = !res_valid || result.ready;
  assign s1_go     = s1_valid && (!s1_result || out_free);
  assign item.ready = !s1_valid || s1_go;
  assign cfg.ready  = 1'b1;
  assign len_wr     = cfg.valid && (cfg_reg_t'(cfg.index) == REG_PAT_LEN);

  assign result.valid    = res_valid;
  assign result.distance = res_distance;
  assign result.rejected = res_rejected;

  assign new_eff  = eff_len(cfg.data);
  assign new_mask = len_mask(new_eff);

  bved_step u_step (
    .eq    (bitmaps[s1_base]),
    .vp    (vp),
    .vn    (vn),
    .mask  (mask),
    .top   (top),
    .score (score),
    .nxt   (nxt)
  );

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_func <= item.func;
      s1_base <= item.base;
      s1_pos  <= item.position;
      s1_last <= item.last;
    end
    if (s1_go && s1_result) begin
      if (nxt.score <= ScoreW'(thr)) begin
        res_distance <= nxt.score[LenW-1:0];
        res_rejected <= 1'b0;
      end else begin
        res_distance <= thr + LenW'(1);
        res_rejected <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      thr       <= '0;
      eff       <= ResetLen;
      top       <= PosW'(ResetLen - LenW'(1));
      mask      <= len_mask(ResetLen);
      vp        <= len_mask(ResetLen);
      vn        <= '0;
      score     <= ScoreW'(ResetLen);
      for (int b = 0; b < Bases; b++) begin
        bitmaps[b] <= '0;
      end
    end else begin
      if (item.valid && item.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go && s1_result) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (s1_go) begin
        if (s1_func == FUNC_LOAD) begin
          for (int b = 0; b < Bases; b++) begin
            bitmaps[b][s1_pos] <= (BaseW'(b) == s1_base);
          end
        end else if (!len_wr) begin
          if (s1_last) begin
            vp    <= mask;
            vn    <= '0;
            score <= ScoreW'(eff);
          end else begin
            vp    <= nxt.vp;
            vn    <= nxt.vn;
            score <= nxt.score;
          end
        end
      end

      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_THRESHOLD: begin
            thr <= (cfg.data > ThrCap) ? ThrCap : cfg.data;
          end
          REG_PAT_LEN: begin
            eff   <= new_eff;
            top   <= PosW'(new_eff - LenW'(1));
            mask  <= new_mask;
            vp    <= new_mask;
            vn    <= '0;
            score <= ScoreW'(new_eff);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### hdl/bved_checker.sv
module bved_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [bved_pkg::LenW-1:0] res_distance,
  input logic                      res_rejected
);
  import bved_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(res_distance) && $stable(res_rejected))
    else $error("result beat changed while stalled");

  a_reject_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_rejected |-> res_distance != '0)
    else $error("rejected beat carries zero distance");

  a_exact_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_rejected |-> res_distance <= ThrCap)
    else $error("exact distance above threshold cap");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat right after reset");

endmodule

bind bit_vector_edit_distance_dna_core bved_checker u_bved_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_distance (result.distance),
  .res_rejected (result.rejected)
);
